>>> src/ptw_pkg.sv
// Shared types and constants for the four-level page table walker.
// Used by ptw_ctrl, ptw_datapath and the top level; no dependencies.
package ptw_pkg;

   localparam int TABLE_WORDS_DEF = 4096;

   localparam int OP_W    = 2;
   localparam int WIDX_W  = 12;
   localparam int ENTRY_W = 64;
   localparam int VA_W    = 48;
   localparam int PA_W    = 52;
   localparam int LEAF_W  = 2;
   localparam int LEVEL_W = 2;
   localparam int IDX_W   = 9;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 64;

   // entry bit positions
   localparam int BIT_PRESENT = 0;
   localparam int BIT_USER    = 2;
   localparam int BIT_PS      = 7;

   localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

   localparam logic [LEAF_W-1:0] LEAF_4K = 2'd0;
   localparam logic [LEAF_W-1:0] LEAF_2M = 2'd1;
   localparam logic [LEAF_W-1:0] LEAF_1G = 2'd2;

   localparam logic CSR_KERNEL_ROOT = 1'b0;
   localparam logic CSR_USER_ROOT   = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_KERNEL = 2'd1,
      OP_USER   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef struct packed {
      logic                capture;
      logic                clear_en;
      logic                wr_en;
      logic                rd_en;
      logic                rd_root;
      logic [LEVEL_W-1:0]  rd_level;
      logic [LEVEL_W-1:0]  chk_level;
      logic                load_result;
      logic                result_zero;
   } ptw_cmd_type;

   typedef struct packed {
      op_type  op;
      logic    entry_ok;
      logic    entry_leaf;
      logic    clear_last;
   } ptw_sts_type;

endpackage

>>> src/ptw_datapath.sv
// Datapath of the page table walker: table memory, clearing counter, root
// registers, request holding registers, walk address generation, result register.
// Depends on ptw_pkg; driven by ptw_ctrl through ptw_cmd_type.
module ptw_datapath
   import ptw_pkg::*;
#(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ptw_cmd_type         cmd,
   output ptw_sts_type         sts,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [PA_W-1:0]     csr_wdata,
   input  logic [OP_W-1:0]     req_op,
   input  logic [WIDX_W-1:0]   req_word_index,
   input  logic [ENTRY_W-1:0]  req_entry_value,
   input  logic [VA_W-1:0]     req_virt_address,
   output logic [PA_W-1:0]     rsp_phys_address,
   output logic                rsp_mapped,
   output logic [LEAF_W-1:0]   rsp_leaf_size
);

   // TABLE_WORDS must be a power of two (the block does not enforce it): word addresses wrap by truncation
   localparam int AW = $clog2(TABLE_WORDS);

   logic [ENTRY_W-1:0]  mem [TABLE_WORDS];

   logic [PA_W-1:0]     kernel_root_ff;
   logic [PA_W-1:0]     user_root_ff;
   logic [AW-1:0]       clr_cnt_ff;
   op_type              op_ff;
   logic [WIDX_W-1:0]   widx_ff;
   logic [ENTRY_W-1:0]  entry_ff;
   logic [VA_W-1:0]     virt_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [PA_W-1:0]     phys_ff;
   logic                mapped_ff;
   logic [LEAF_W-1:0]   leaf_ff;

   logic [PA_W-13:0]    ptr;
   logic [IDX_W-1:0]    idx;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   logic [ENTRY_W-1:0]  mem_wd;
   logic                ok;
   logic                leaf;
   logic [PA_W-1:0]     phys_in;
   logic [LEAF_W-1:0]   leaf_in;

   // root registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_root_ff <= '0;
         user_root_ff   <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_KERNEL_ROOT) kernel_root_ff <= csr_wdata;
         else                              user_root_ff   <= csr_wdata;
      end
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_op);
         widx_ff  <= req_word_index;
         entry_ff <= req_entry_value;
         virt_ff  <= req_virt_address;
      end
   end

   // next table pointer and index for the level being read
   always_comb begin
      if (cmd.rd_root) begin
         ptr = (op_ff == OP_USER) ? user_root_ff[PA_W-1:12] : kernel_root_ff[PA_W-1:12];
      end else begin
         ptr = rd_data_ff[PA_W-1:12];
      end
      unique case (cmd.rd_level)
         LVL_PML4: idx = virt_ff[47:39];
         LVL_PDPT: idx = virt_ff[38:30];
         LVL_PD:   idx = virt_ff[29:21];
         LVL_PT:   idx = virt_ff[20:12];
         default:  idx = virt_ff[20:12];
      endcase
   end

   assign rd_addr = AW'({ptr, idx});

   assign mem_we = cmd.clear_en | cmd.wr_en;
   assign mem_wa = cmd.clear_en ? clr_cnt_ff : AW'(widx_ff);
   assign mem_wd = cmd.clear_en ? '0 : entry_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   // check of the entry fetched at chk_level
   always_comb begin
      if (op_ff == OP_USER) begin
         ok   = rd_data_ff[BIT_PRESENT] & rd_data_ff[BIT_USER];
         leaf = rd_data_ff[BIT_PS] &
                ((cmd.chk_level == LVL_PDPT) || (cmd.chk_level == LVL_PD));
      end else begin
         ok   = rd_data_ff[BIT_PRESENT];
         leaf = rd_data_ff[BIT_PS] && (cmd.chk_level == LVL_PD);
      end
   end

   always_comb begin
      if (cmd.chk_level == LVL_PT) begin
         leaf_in = LEAF_4K;
         phys_in = {rd_data_ff[PA_W-1:12], virt_ff[11:0]};
      end else if (cmd.chk_level == LVL_PD) begin
         leaf_in = LEAF_2M;
         phys_in = {rd_data_ff[PA_W-1:21], virt_ff[20:0]};
      end else begin
         leaf_in = LEAF_1G;
         phys_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (cmd.result_zero || !ok) begin
            phys_ff   <= '0;
            mapped_ff <= 1'b0;
            leaf_ff   <= LEAF_4K;
         end else begin
            phys_ff   <= (op_ff == OP_KERNEL) ? phys_in : '0;
            mapped_ff <= 1'b1;
            leaf_ff   <= leaf_in;
         end
      end
   end

   assign sts.op         = op_ff;
   assign sts.entry_ok   = ok;
   assign sts.entry_leaf = leaf;
   assign sts.clear_last = &clr_cnt_ff;

   assign rsp_phys_address = phys_ff;
   assign rsp_mapped       = mapped_ff;
   assign rsp_leaf_size    = leaf_ff;

endmodule

>>> src/ptw_ctrl.sv
// Controller of the page table walker: clearing sweep, request handshake,
// level sequencing of the walk and the response valid flag.
// Depends on ptw_pkg; drives ptw_datapath through ptw_cmd_type.
module ptw_ctrl
   import ptw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ptw_sts_type  sts,
   output ptw_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_CHECK
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   logic                rsp_valid_ff;
   logic                out_free;
   logic                walk_op;
   logic                final_level;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign walk_op     = (sts.op == OP_KERNEL) || (sts.op == OP_USER);
   assign final_level = !sts.entry_ok || sts.entry_leaf || (level_ff == LVL_PT);

   always_comb begin
      cmd             = '0;
      cmd.chk_level   = level_ff;
      state_in        = state_ff;
      level_in        = level_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            if (walk_op) begin
               cmd.rd_en    = 1'b1;
               cmd.rd_root  = 1'b1;
               cmd.rd_level = LVL_PML4;
               level_in     = LVL_PML4;
               state_in     = ST_CHECK;
            end else if (out_free) begin
               cmd.wr_en       = (sts.op == OP_WRITE);
               cmd.load_result = 1'b1;
               cmd.result_zero = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (final_level) begin
               if (out_free) begin
                  cmd.load_result = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_level = level_ff + 1'b1;
               level_in     = level_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         level_ff     <= LVL_PML4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         if (cmd.load_result)  rsp_valid_ff <= 1'b1;
         else if (rsp_tready)  rsp_valid_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> src/four_level_page_table_walker.sv
// Four-level page table walker. A write or no-op request is answered from ST_START;
// a walk then reads one level at a time, stopping at a leaf, a failed entry or PT.
// One request at a time: the levels of a walk are read one after another, set by the
// single read port of the table memory and one dependent read per level.
// Reset is synchronous; afterwards the table memory is zeroed by a sweep over all
// TABLE_WORDS words during which req_tready stays low (csr writes still taken).
module four_level_page_table_walker
   import ptw_pkg::*;
#(
   parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [OP_W-1:0]        req_tuser,   // operation
   // word_index[11:0], entry_value[75:12], virt_address[123:76], zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // phys_address[51:0], mapped[52], leaf_size[54:53], zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [PA_W-1:0]        csr_wdata
);

   ptw_cmd_type        cmd;
   ptw_sts_type        sts;
   logic [PA_W-1:0]    phys_address;
   logic               mapped;
   logic [LEAF_W-1:0]  leaf_size;

   ptw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ptw_datapath #(
      .TABLE_WORDS (TABLE_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_op           (req_tuser),
      .req_word_index   (req_tdata[11:0]),
      .req_entry_value  (req_tdata[75:12]),
      .req_virt_address (req_tdata[123:76]),
      .rsp_phys_address (phys_address),
      .rsp_mapped       (mapped),
      .rsp_leaf_size    (leaf_size)
   );

   assign rsp_tdata = {{(RSP_DATA_W - PA_W - 1 - LEAF_W){1'b0}}, leaf_size, mapped, phys_address};

endmodule

>>> tb/tb_four_level_page_table_walker.sv
// Self-checking testbench for four_level_page_table_walker: builds page table chains
// through write requests, walks them, and checks each response against a local model.
// Depends on ptw_pkg and the walker RTL only.
`timescale 1ns / 1ps

module tb_four_level_page_table_walker;
   import ptw_pkg::*;

   localparam int          TABLE_WORDS = 4096;
   localparam int          TABLE_AW    = $clog2(TABLE_WORDS);
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          DRAIN_WAIT  = 20;
   localparam logic [63:0] MASK_4K     = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] MASK_2M     = 64'h000F_FFFF_FFE0_0000;
   localparam logic [63:0] IDX_MASK    = 64'h1FF;

   typedef struct packed {
      op_type              op;
      logic [WIDX_W-1:0]   widx;
      logic [ENTRY_W-1:0]  entry;
      logic [VA_W-1:0]     va;
   } walk_req_type;

   typedef struct packed {
      logic [PA_W-1:0]     pa;
      logic                mapped;
      logic [LEAF_W-1:0]   leaf;
   } walk_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser = '0;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic                   csr_index = CSR_KERNEL_ROOT;
   logic [PA_W-1:0]        csr_wdata = '0;

   // model state
   logic [ENTRY_W-1:0] page_table [TABLE_WORDS];
   logic [PA_W-1:0]    kernel_root_q = '0;
   logic [PA_W-1:0]    user_root_q = '0;

   walk_req_type queued_reqs[$];
   walk_rsp_type due_results[$];
   walk_req_type cur_req;
   logic         calm = 1'b0;
   int           errors = 0;
   int           cycle_count = 0;

   four_level_page_table_walker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < TABLE_WORDS; i++) page_table[TABLE_AW'(i)] = '0;
   end

   function automatic logic [ENTRY_W-1:0] fetch_entry(logic [63:0] base, logic [VA_W-1:0] va,
                                                      int shift);
      logic [63:0] word;
      word = ((base & MASK_4K) >> 3) + ((64'(va) >> shift) & IDX_MASK);
      return page_table[TABLE_AW'(word % TABLE_WORDS)];
   endfunction

   function automatic walk_rsp_type kernel_translate(logic [VA_W-1:0] va);
      walk_rsp_type res;
      logic [63:0]  e;
      res = '0;
      e = fetch_entry(64'(kernel_root_q), va, 39);
      if (!e[BIT_PRESENT]) return res;
      // PS at PDPT level is not a leaf for kernel walks
      e = fetch_entry(e, va, 30);
      if (!e[BIT_PRESENT]) return res;
      e = fetch_entry(e, va, 21);
      if (!e[BIT_PRESENT]) return res;
      if (e[BIT_PS]) begin
         res.pa = PA_W'((e & MASK_2M) | (64'(va) & 64'h1F_FFFF));
         res.mapped = 1'b1;
         res.leaf = LEAF_2M;
         return res;
      end
      e = fetch_entry(e, va, 12);
      if (!e[BIT_PRESENT]) return res;
      res.pa = PA_W'((e & MASK_4K) | (64'(va) & 64'hFFF));
      res.mapped = 1'b1;
      res.leaf = LEAF_4K;
      return res;
   endfunction

   function automatic walk_rsp_type user_check(logic [VA_W-1:0] va);
      walk_rsp_type res;
      logic [63:0]  e;
      res = '0;
      e = fetch_entry(64'(user_root_q), va, 39);
      if (!(e[BIT_PRESENT] && e[BIT_USER])) return res;
      e = fetch_entry(e, va, 30);
      if (!(e[BIT_PRESENT] && e[BIT_USER])) return res;
      if (e[BIT_PS]) begin
         res.mapped = 1'b1;
         res.leaf = LEAF_1G;
         return res;
      end
      e = fetch_entry(e, va, 21);
      if (!(e[BIT_PRESENT] && e[BIT_USER])) return res;
      if (e[BIT_PS]) begin
         res.mapped = 1'b1;
         res.leaf = LEAF_2M;
         return res;
      end
      e = fetch_entry(e, va, 12);
      if (!(e[BIT_PRESENT] && e[BIT_USER])) return res;
      res.mapped = 1'b1;
      res.leaf = LEAF_4K;
      return res;
   endfunction

   function automatic walk_rsp_type compute_result(walk_req_type r);
      walk_rsp_type res;
      res = '0;
      unique case (r.op)
         OP_WRITE: begin
            page_table[TABLE_AW'(r.widx % TABLE_WORDS)] = r.entry;
         end
         OP_KERNEL: begin
            res = kernel_translate(r.va);
         end
         OP_USER: begin
            res = user_check(r.va);
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic walk_req_type mk_req(op_type op, logic [WIDX_W-1:0] widx,
                                           logic [ENTRY_W-1:0] entry, logic [VA_W-1:0] va);
      walk_req_type r;
      r.op = op;
      r.widx = widx;
      r.entry = entry;
      r.va = va;
      return r;
   endfunction

   // queues a write of one entry per level along the path of va (each may be dropped at random), then walks it
   task automatic add_walk_chain(op_type walk_op, logic [PA_W-1:0] root, logic [VA_W-1:0] va);
      logic [63:0]      table_addr;
      logic [63:0]      pte;
      logic [63:0]      word;
      logic [VA_W-1:0]  va2;
      table_addr = 64'(root);
      for (int lvl = 0; lvl < 4; lvl++) begin
         pte = {$urandom, $urandom};
         pte[BIT_PRESENT] = ($urandom_range(99) < 92);
         pte[BIT_USER] = ($urandom_range(99) < 88);
         pte[BIT_PS] = (lvl == 1 || lvl == 2) ? ($urandom_range(99) < 25)
                                              : 1'($urandom_range(1));
         word = ((table_addr & MASK_4K) >> 3) + ((64'(va) >> (39 - 9 * lvl)) & IDX_MASK);
         if ($urandom_range(99) < 95)
            queued_reqs.push_back(mk_req(OP_WRITE, WIDX_W'(word % TABLE_WORDS), pte, '0));
         table_addr = pte;
      end
      queued_reqs.push_back(mk_req(walk_op, WIDX_W'($urandom), {$urandom, $urandom}, va));
      if ($urandom_range(1)) begin
         va2 = va;
         if ($urandom_range(1)) va2[11:0] = 12'($urandom);
         else va2[20:0] = 21'($urandom);
         queued_reqs.push_back(mk_req(walk_op == OP_KERNEL ? OP_USER : OP_KERNEL,
                                      WIDX_W'($urandom), {$urandom, $urandom}, va2));
      end
   endtask

   task automatic write_csr(logic idx, logic [PA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_KERNEL_ROOT) kernel_root_q = value;
      else user_root_q = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (queued_reqs.size() != 0 || req_tvalid || due_results.size() != 0);
   endtask

   // request driver; prediction happens at the accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) due_results.push_back(compute_result(cur_req));
         if (!req_tvalid || req_tready) begin
            if (queued_reqs.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
               cur_req = queued_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_req.op;
               req_tdata <= {4'b0, cur_req.va, cur_req.entry, cur_req.widx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      walk_rsp_type want;
      walk_rsp_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pa = rsp_tdata[51:0];
            got.mapped = rsp_tdata[52];
            got.leaf = rsp_tdata[54:53];
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual pa=%h mapped=%b leaf=%0d",
                        $realtime, got.pa, got.mapped, got.leaf);
            end else begin
               want = due_results.pop_front();
               if (got.pa !== want.pa) begin
                  errors++;
                  $display("%0t: phys_address mismatch, expected %h, actual %h",
                           $realtime, want.pa, got.pa);
               end
               if (got.mapped !== want.mapped) begin
                  errors++;
                  $display("%0t: mapped mismatch, expected %b, actual %b",
                           $realtime, want.mapped, got.mapped);
               end
               if (got.leaf !== want.leaf) begin
                  errors++;
                  $display("%0t: leaf_size mismatch, expected %0d, actual %0d",
                           $realtime, want.leaf, got.leaf);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 37);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [PA_W-1:0] k_roots [5];
      logic [PA_W-1:0] u_roots [5];
      int              count;
      k_roots = '{52'hF_FFFF_FFFF_FFFF, 52'($urandom), 52'h0, 52'({$urandom, $urandom}),
                  52'h0_2000};
      u_roots = '{52'hF_FFFF_FFFF_FFFF, 52'({$urandom, $urandom}), 52'h0_0FFF, 52'($urandom),
                  52'h0_3000};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: both roots at their reset value of zero
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'h0));
      queued_reqs.push_back(mk_req(OP_NONE, 12'hFFF, '1, '1));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd0, 64'h1087, 48'h0));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd512, 64'h2087, 48'h0));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd1024, 64'h3007, 48'h0));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd1536, 64'h800F_FFFF_FFFF_F005, 48'h0));
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'h0ABC));
      queued_reqs.push_back(mk_req(OP_USER, 12'h0, 64'h0, 48'h0ABC));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd1024, 64'h000F_FFFF_FFE0_0087, 48'h0));
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'h1F_FFFF));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd512, 64'h2007, 48'h0));
      queued_reqs.push_back(mk_req(OP_USER, 12'h0, 64'h0, 48'h1F_FFFF));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd1024, 64'h3003, 48'h0));
      queued_reqs.push_back(mk_req(OP_USER, 12'h0, 64'h0, 48'h123));
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'h123));
      // an all-ones entry at word 511 leads to the all-ones entry at the top of the memory, which wraps onto itself
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd511, '1, 48'h0));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'hFFF, '1, 48'h0));
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'hFFFF_FFFF_FFFF));
      queued_reqs.push_back(mk_req(OP_USER, 12'h0, 64'h0, 48'hFFFF_FFFF_FFFF));
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'h0080_0000_0000));
      queued_reqs.push_back(mk_req(OP_WRITE, 12'd0, 64'h0, 48'h0));
      queued_reqs.push_back(mk_req(OP_KERNEL, 12'h0, 64'h0, 48'h0ABC));
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_KERNEL_ROOT, k_roots[p]);
         write_csr(CSR_USER_ROOT, u_roots[p]);
         calm = (p == 1);
         count = 0;
         while (count < 100) begin
            if ($urandom_range(99) < 80) begin
               if ($urandom_range(1))
                  add_walk_chain(OP_KERNEL, kernel_root_q, VA_W'({$urandom, $urandom}));
               else
                  add_walk_chain(OP_USER, user_root_q, VA_W'({$urandom, $urandom}));
            end else begin
               queued_reqs.push_back(mk_req(op_type'($urandom_range(3)), WIDX_W'($urandom),
                                            {$urandom, $urandom}, VA_W'({$urandom, $urandom})));
            end
            count = queued_reqs.size();
         end
         // sender holds off until every response of the phase is back
         wait_drained();
         calm = 1'b0;
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
src/ptw_pkg.sv
src/ptw_datapath.sv
src/ptw_ctrl.sv
src/four_level_page_table_walker.sv
tb/tb_four_level_page_table_walker.sv
